@@ hw/rtl/gfc_pkg.sv @@
// ----------------------------------------------------------------------------
// gfc_pkg: shared types and constants of the gammatone filter channel
// Multiplier request/response types, sequencer codes, fixed-point constants
// and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gfc_pkg;

   // shared multiplier operand and product widths
   localparam int MUL_A_W = 65;
   localparam int MUL_B_W = 41;
   localparam int MUL_P_W = 107;
   localparam int MUL_N_W = 6;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 40;

   localparam logic signed [31:0] ONE_Q30    = 32'sd1073741824;
   localparam logic signed [33:0] PI_Q30     = 34'sd3373259426;
   localparam logic signed [34:0] PI_Q24     = 35'sd52707179;
   localparam logic signed [34:0] TWO_PI_Q24 = 35'sd105414358;
   localparam logic signed [40:0] KINV_Q32   = 41'sd2608131496;

   // 2*pi multiples tried when reducing a phase jump
   localparam int WRAP_STEPS = 7;

   typedef enum logic [2:0] {
      CSR_DECAY = 3'd0,
      CSR_GAIN  = 3'd1,
      CSR_COS   = 3'd2,
      CSR_SIN   = 3'd3,
      CSR_HWR   = 3'd4,
      CSR_CF    = 3'd5,
      CSR_FS    = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      MUL_IDLE,
      MUL_RUN,
      MUL_ROUND
   } mul_state_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_CORD_INIT,
      ST_CORDIC,
      ST_WRAP_INIT,
      ST_WRAP,
      ST_WRAP_FIX,
      ST_DONE
   } back_state_type;

   typedef enum logic [4:0] {
      OP_A2, OP_A3, OP_A4,
      OP_DRV, OP_P0, OP_P1, OP_P2, OP_P3, OP_U0, OP_U1,
      OP_RE0, OP_RE1, OP_MEM, OP_ENVK, OP_ENV, OP_FREQ,
      OP_NC0, OP_NC1, OP_NS0, OP_NS1
   } op_type;

   typedef struct packed {
      logic                      start;
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
      logic [MUL_N_W-1:0]        shift;
   } mul_req_type;

   typedef struct packed {
      logic               done;
      logic signed [63:0] result;
   } mul_rsp_type;

   // arctangent of 2^-i in Q2.30
   function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
      logic signed [33:0] v;
      unique case (idx)
         5'd0:  v = 34'sh03243F6A8;
         5'd1:  v = 34'sh01DAC6705;
         5'd2:  v = 34'sh00FADBAFC;
         5'd3:  v = 34'sh007F56EA6;
         5'd4:  v = 34'sh003FEAB76;
         5'd5:  v = 34'sh001FFD55B;
         5'd6:  v = 34'sh000FFFAAA;
         5'd7:  v = 34'sh0007FFF55;
         5'd8:  v = 34'sh0003FFFEA;
         5'd9:  v = 34'sh0001FFFFD;
         5'd10: v = 34'sh0000FFFFF;
         5'd11: v = 34'sh00007FFFF;
         5'd12: v = 34'sh00003FFFF;
         5'd13: v = 34'sh00001FFFF;
         5'd14: v = 34'sh00000FFFF;
         5'd15: v = 34'sh000007FFF;
         5'd16: v = 34'sh000003FFF;
         5'd17: v = 34'sh000001FFF;
         5'd18: v = 34'sh000000FFF;
         5'd19: v = 34'sh0000007FF;
         5'd20: v = 34'sh0000003FF;
         5'd21: v = 34'sh0000001FF;
         5'd22: v = 34'sh0000000FF;
         5'd23: v = 34'sh00000007F;
         5'd24: v = 34'sh00000003F;
         5'd25: v = 34'sh00000001F;
         5'd26: v = 34'sh00000000F;
         5'd27: v = 34'sh000000008;
         5'd28: v = 34'sh000000004;
         5'd29: v = 34'sh000000002;
         5'd30: v = 34'sh000000001;
         default: v = 34'sh000000000;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gfc_front.sv @@
// ----------------------------------------------------------------------------
// gfc_front: input stage of the gammatone filter channel
// Accepts sample words, splits sample and block start flag, and holds them
// in a two-entry queue in front of the arithmetic sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gfc_front #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
   input  logic                           in_block_start,
   output logic                           q_valid,
   input  logic                           q_ready,
   output logic signed [SAMPLE_WIDTH-1:0] q_sample,
   output logic                           q_block_start
);

   logic signed [SAMPLE_WIDTH-1:0] sample_mem_ff [2];
   logic                           start_mem_ff  [2];
   logic                           wr_ptr_ff, rd_ptr_ff;
   logic [1:0]                     count_ff;
   logic                           push, pop;

   assign in_ready      = (count_ff != 2'd2);
   assign q_valid       = (count_ff != 2'd0);
   assign q_sample      = sample_mem_ff[rd_ptr_ff];
   assign q_block_start = start_mem_ff[rd_ptr_ff];
   assign push          = in_valid & in_ready;
   assign pop           = q_valid & q_ready;

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         sample_mem_ff[wr_ptr_ff] <= in_sample;
         start_mem_ff[wr_ptr_ff]  <= in_block_start;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         if (push && !pop)      count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/gfc_mul.sv @@
// ----------------------------------------------------------------------------
// gfc_mul: shared serial multiplier with rounding
// Radix-2 shift-add product of a 65-bit and a 41-bit signed operand, then
// round to nearest (ties up), arithmetic shift and saturation to 64 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gfc_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  gfc_pkg::mul_req_type req,
   output gfc_pkg::mul_rsp_type rsp
);

   localparam int AW = gfc_pkg::MUL_A_W;
   localparam int BW = gfc_pkg::MUL_B_W;
   localparam int PW = gfc_pkg::MUL_P_W;
   localparam int NW = gfc_pkg::MUL_N_W;

   gfc_pkg::mul_state_type state_ff, state_in;
   logic signed [AW:0]   aeff_ff, aeff_in;
   logic [BW-1:0]        mag_ff, mag_in;
   logic signed [PW-1:0] acc_ff, acc_in;
   logic [NW-1:0]        cnt_ff, cnt_in;
   logic [NW-1:0]        shift_ff, shift_in;

   logic signed [AW:0]   a_ext;
   logic signed [PW-1:0] rounded, shifted;

   // round and saturate the finished product
   always_comb begin
      rounded = acc_ff + (PW'(1) <<< (shift_ff - NW'(1)));
      shifted = rounded >>> shift_ff;
      rsp.done = (state_ff == gfc_pkg::MUL_ROUND);
      if (shifted[PW-1:63] == {(PW-63){shifted[PW-1]}}) begin
         rsp.result = shifted[63:0];
      end else begin
         rsp.result = shifted[PW-1] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
   end

   // sequence: load, one multiplier bit per cycle, round
   always_comb begin
      state_in = state_ff;
      aeff_in  = aeff_ff;
      mag_in   = mag_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      a_ext    = (AW + 1)'($signed(req.a));
      unique case (state_ff)
         gfc_pkg::MUL_IDLE: begin
            if (req.start) begin
               // sign of b moves onto a, b keeps its magnitude
               aeff_in  = req.b[BW-1] ? -a_ext : a_ext;
               mag_in   = req.b[BW-1] ? BW'(-$signed(req.b)) : req.b;
               acc_in   = '0;
               cnt_in   = NW'(BW);
               shift_in = req.shift;
               state_in = gfc_pkg::MUL_RUN;
            end
         end
         gfc_pkg::MUL_RUN: begin
            acc_in = (acc_ff <<< 1) + (mag_ff[BW-1] ? PW'(aeff_ff) : PW'(0));
            mag_in = mag_ff << 1;
            cnt_in = cnt_ff - NW'(1);
            if (cnt_ff == NW'(1)) state_in = gfc_pkg::MUL_ROUND;
         end
         gfc_pkg::MUL_ROUND: begin
            state_in = gfc_pkg::MUL_IDLE;
         end
         default: state_in = gfc_pkg::MUL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gfc_pkg::MUL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      aeff_ff  <= aeff_in;
      mag_ff   <= mag_in;
      acc_ff   <= acc_in;
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
   end

endmodule

`default_nettype wire

@@ hw/rtl/gfc_back.sv @@
// ----------------------------------------------------------------------------
// gfc_back: arithmetic sequencer of the gammatone filter channel
// Holds configuration and filter state, steps each sample through the
// shared multiplier, the CORDIC vectoring loop and phase unwrapping, and
// presents the result in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gfc_back #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int TAP_WIDTH    = 56,
   parameter int CORDIC_STEPS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [gfc_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [gfc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                q_valid,
   output logic                                q_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]      q_sample,
   input  logic                                q_block_start,
   output gfc_pkg::mul_req_type                mul_req,
   input  gfc_pkg::mul_rsp_type                mul_rsp,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [31:0]                         out_membrane,
   output logic [30:0]                         out_envelope,
   output logic [31:0]                         out_phase,
   output logic [25:0]                         out_prev_freq,
   output logic                                out_prev_freq_valid
);

   localparam int AW = gfc_pkg::MUL_A_W;
   localparam int BW = gfc_pkg::MUL_B_W;
   localparam int NW = gfc_pkg::MUL_N_W;
   localparam int CW = $clog2(CORDIC_STEPS);
   localparam logic signed [63:0] TMAX =
      $signed({1'b0, {63{1'b1}}}) >>> (64 - TAP_WIDTH);
   localparam logic signed [63:0] TMIN = ~TMAX;

   // ---- saturation helpers ----
   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] p,
                                                    input logic signed [63:0] q);
      logic signed [64:0] s;
      s = 65'(p) + 65'(q);
      if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] p,
                                                    input logic signed [63:0] q);
      logic signed [64:0] s;
      s = 65'(p) - 65'(q);
      if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sat_tap(input logic signed [63:0] v);
      if (v > TMAX) return TMAX;
      if (v < TMIN) return TMIN;
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647)  return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [25:0] sat26(input logic signed [63:0] v);
      if (v > 64'sd33554431)  return 26'sh1FFFFFF;
      if (v < -64'sd33554432) return 26'sh2000000;
      return v[25:0];
   endfunction

   // ---- configuration registers ----
   logic [31:0]        decay_ff;
   logic [39:0]        gain_ff;
   logic signed [31:0] cos_step_ff, sin_step_ff;
   logic               hwr_ff;
   logic [23:0]        cf_ff, fs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff    <= 32'd4072000000;
         gain_ff     <= 40'd2903000;
         cos_step_ff <= 32'sd992000000;
         sin_step_ff <= 32'sd410900000;
         hwr_ff      <= 1'b0;
         cf_ff       <= 24'd256000;
         fs_ff       <= 24'd651900;
      end else if (csr_we) begin
         unique case (gfc_pkg::csr_index_type'(csr_addr))
            gfc_pkg::CSR_DECAY: decay_ff    <= csr_wdata[31:0];
            gfc_pkg::CSR_GAIN:  gain_ff     <= csr_wdata[39:0];
            gfc_pkg::CSR_COS:   cos_step_ff <= csr_wdata[31:0];
            gfc_pkg::CSR_SIN:   sin_step_ff <= csr_wdata[31:0];
            gfc_pkg::CSR_HWR:   hwr_ff      <= csr_wdata[0];
            gfc_pkg::CSR_CF:    cf_ff       <= csr_wdata[23:0];
            gfc_pkg::CSR_FS:    fs_ff       <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   // ---- sequencer state ----
   gfc_pkg::back_state_type state_ff, state_in;
   gfc_pkg::op_type         op_ff, op_in;
   logic                    lane_ff, lane_in;
   logic signed [SAMPLE_WIDTH-1:0] x_ff, x_in;
   logic signed [32:0]      a2_ff, a2_in, a3_ff, a3_in, a4_ff, a4_in;
   logic signed [63:0]      acc_ff, acc_in;
   logic signed [TAP_WIDTH-1:0] p0_ff, p0_in, ur_ff, ur_in, ui_ff, ui_in;
   logic signed [TAP_WIDTH-1:0] rt_ff [4];
   logic signed [TAP_WIDTH-1:0] rt_in [4];
   logic signed [TAP_WIDTH-1:0] it_ff [4];
   logic signed [TAP_WIDTH-1:0] it_in [4];
   logic signed [63:0]      re_ff, re_in;
   logic signed [31:0]      mem_ff, mem_in;
   logic signed [BW-1:0]    envk_ff, envk_in;
   logic signed [63:0]      cx_ff, cx_in, cy_ff, cy_in;
   logic signed [33:0]      z_ff, z_in;
   logic [CW-1:0]           step_ff, step_in;
   logic [30:0]             env_ff, env_in;
   logic signed [34:0]      d_ff, d_in, m_ff, m_in;
   logic                    neg_ff, neg_in, wrap_ff, wrap_in;
   logic [2:0]              k_ff, k_in;
   logic signed [31:0]      ph_ff, ph_in;
   logic signed [33:0]      diff_ff, diff_in;
   logic signed [25:0]      freq_ff, freq_in;
   logic                    fvalid_ff, fvalid_in;
   logic signed [63:0]      tmp_ff, tmp_in;
   logic signed [31:0]      nc_ff, nc_in;
   logic signed [31:0]      osc_cos_ff, osc_cos_in, osc_sin_ff, osc_sin_in;
   logic signed [31:0]      last_ff, last_in;
   logic                    havep_ff, havep_in;
   logic                    ovalid_ff, ovalid_in;
   logic [31:0]             omem_ff, omem_in, oph_ff, oph_in;
   logic [30:0]             oenv_ff, oenv_in;
   logic [25:0]             ofreq_ff, ofreq_in;
   logic                    ofv_ff, ofv_in;

   // ---- operand selection for the shared multiplier ----
   logic signed [32:0]   a_s;
   logic signed [BW-1:0] c0, c1, c2, c3;
   logic signed [TAP_WIDTH-1:0] tap0, tap1, tap2, tap3;
   logic signed [31:0]   osc_lane;

   always_comb begin
      a_s      = $signed({1'b0, decay_ff});
      c0       = BW'(a_s) <<< 2;
      c1       = -(BW'(a2_ff) * 41'sd6);
      c2       = BW'(a3_ff) <<< 2;
      c3       = -BW'(a4_ff);
      tap0     = lane_ff ? it_ff[0] : rt_ff[0];
      tap1     = lane_ff ? it_ff[1] : rt_ff[1];
      tap2     = lane_ff ? it_ff[2] : rt_ff[2];
      tap3     = lane_ff ? it_ff[3] : rt_ff[3];
      osc_lane = lane_ff ? osc_sin_ff : osc_cos_ff;

      mul_req.start = (state_ff == gfc_pkg::ST_ISSUE);
      mul_req.a     = '0;
      mul_req.b     = '0;
      mul_req.shift = NW'(32);
      unique case (op_ff)
         gfc_pkg::OP_A2: begin
            mul_req.a = AW'(a_s); mul_req.b = BW'(a_s);
         end
         gfc_pkg::OP_A3: begin
            mul_req.a = AW'(a2_ff); mul_req.b = BW'(a_s);
         end
         gfc_pkg::OP_A4: begin
            mul_req.a = AW'(a3_ff); mul_req.b = BW'(a_s);
         end
         gfc_pkg::OP_DRV: begin
            mul_req.a = AW'(osc_lane); mul_req.b = BW'(x_ff);
            mul_req.shift = NW'(SAMPLE_WIDTH - 3);
         end
         gfc_pkg::OP_P0: begin mul_req.a = AW'(tap0); mul_req.b = c0; end
         gfc_pkg::OP_P1: begin mul_req.a = AW'(tap1); mul_req.b = c1; end
         gfc_pkg::OP_P2: begin mul_req.a = AW'(tap2); mul_req.b = c2; end
         gfc_pkg::OP_P3: begin mul_req.a = AW'(tap3); mul_req.b = c3; end
         gfc_pkg::OP_U0: begin mul_req.a = AW'(tap0); mul_req.b = c0; end
         gfc_pkg::OP_U1: begin mul_req.a = AW'(tap1); mul_req.b = BW'(a2_ff); end
         gfc_pkg::OP_RE0: begin
            mul_req.a = AW'(ur_ff); mul_req.b = BW'(osc_cos_ff);
            mul_req.shift = NW'(30);
         end
         gfc_pkg::OP_RE1: begin
            mul_req.a = AW'(ui_ff); mul_req.b = BW'(osc_sin_ff);
            mul_req.shift = NW'(30);
         end
         gfc_pkg::OP_MEM: begin
            mul_req.a = AW'(re_ff); mul_req.b = $signed({1'b0, gain_ff});
            mul_req.shift = NW'(41);
         end
         gfc_pkg::OP_ENVK: begin
            mul_req.a = $signed({25'd0, gain_ff}); mul_req.b = gfc_pkg::KINV_Q32;
         end
         gfc_pkg::OP_ENV: begin
            mul_req.a = AW'(cx_ff); mul_req.b = envk_ff;
            mul_req.shift = NW'(39);
         end
         gfc_pkg::OP_FREQ: begin
            mul_req.a = AW'(diff_ff); mul_req.b = BW'($signed({1'b0, fs_ff}));
            mul_req.shift = NW'(24);
         end
         gfc_pkg::OP_NC0: begin
            mul_req.a = AW'(cos_step_ff); mul_req.b = BW'(osc_cos_ff);
            mul_req.shift = NW'(30);
         end
         gfc_pkg::OP_NC1: begin
            mul_req.a = AW'(sin_step_ff); mul_req.b = BW'(osc_sin_ff);
            mul_req.shift = NW'(30);
         end
         gfc_pkg::OP_NS0: begin
            mul_req.a = AW'(cos_step_ff); mul_req.b = BW'(osc_sin_ff);
            mul_req.shift = NW'(30);
         end
         gfc_pkg::OP_NS1: begin
            mul_req.a = AW'(sin_step_ff); mul_req.b = BW'(osc_cos_ff);
            mul_req.shift = NW'(30);
         end
         default: ;
      endcase
   end

   // ---- next state ----
   logic signed [63:0] res, s64, cx0, cy0;
   logic signed [34:0] ph0, dnew, tnew, lim, mm, r, psum;
   logic signed [31:0] phs;

   always_comb begin
      state_in = state_ff;  op_in = op_ff;  lane_in = lane_ff;  x_in = x_ff;
      a2_in = a2_ff;  a3_in = a3_ff;  a4_in = a4_ff;  acc_in = acc_ff;
      p0_in = p0_ff;  ur_in = ur_ff;  ui_in = ui_ff;  rt_in = rt_ff;  it_in = it_ff;
      re_in = re_ff;  mem_in = mem_ff;  envk_in = envk_ff;
      cx_in = cx_ff;  cy_in = cy_ff;  z_in = z_ff;  step_in = step_ff;
      env_in = env_ff;  d_in = d_ff;  m_in = m_ff;  neg_in = neg_ff;
      wrap_in = wrap_ff;  k_in = k_ff;  ph_in = ph_ff;  diff_in = diff_ff;
      freq_in = freq_ff;  fvalid_in = fvalid_ff;  tmp_in = tmp_ff;  nc_in = nc_ff;
      osc_cos_in = osc_cos_ff;  osc_sin_in = osc_sin_ff;
      last_in = last_ff;  havep_in = havep_ff;
      ovalid_in = ovalid_ff;  omem_in = omem_ff;  oenv_in = oenv_ff;
      oph_in = oph_ff;  ofreq_in = ofreq_ff;  ofv_in = ofv_ff;
      res  = $signed(mul_rsp.result);
      s64  = '0;  cx0 = '0;  cy0 = '0;
      ph0  = '0;  dnew = '0;  tnew = '0;  lim = '0;  mm = '0;  r = '0;
      psum = '0;  phs = '0;
      q_ready = (state_ff == gfc_pkg::ST_IDLE);

      // output register drains independently of the sequencer
      if (ovalid_ff && out_ready) ovalid_in = 1'b0;

      unique case (state_ff)
         gfc_pkg::ST_IDLE: begin
            if (q_valid) begin
               x_in = q_sample;
               if (q_block_start) begin
                  osc_cos_in = gfc_pkg::ONE_Q30;
                  osc_sin_in = '0;
                  last_in    = '0;
                  havep_in   = 1'b0;
               end
               op_in    = gfc_pkg::OP_A2;
               state_in = gfc_pkg::ST_ISSUE;
            end
         end

         gfc_pkg::ST_ISSUE: state_in = gfc_pkg::ST_WAIT;

         gfc_pkg::ST_WAIT: begin
            if (mul_rsp.done) begin
               state_in = gfc_pkg::ST_ISSUE;
               unique case (op_ff)
                  gfc_pkg::OP_A2: begin a2_in = 33'(res); op_in = gfc_pkg::OP_A3; end
                  gfc_pkg::OP_A3: begin a3_in = 33'(res); op_in = gfc_pkg::OP_A4; end
                  gfc_pkg::OP_A4: begin
                     a4_in = 33'(res); lane_in = 1'b0; op_in = gfc_pkg::OP_DRV;
                  end
                  gfc_pkg::OP_DRV: begin acc_in = res; op_in = gfc_pkg::OP_P0; end
                  gfc_pkg::OP_P0: begin
                     acc_in = sat_add64(acc_ff, res); op_in = gfc_pkg::OP_P1;
                  end
                  gfc_pkg::OP_P1: begin
                     acc_in = sat_add64(acc_ff, res); op_in = gfc_pkg::OP_P2;
                  end
                  gfc_pkg::OP_P2: begin
                     acc_in = sat_add64(acc_ff, res); op_in = gfc_pkg::OP_P3;
                  end
                  gfc_pkg::OP_P3: begin
                     s64    = sat_tap(sat_add64(acc_ff, res));
                     acc_in = s64;
                     p0_in  = TAP_WIDTH'(s64);
                     op_in  = gfc_pkg::OP_U0;
                  end
                  gfc_pkg::OP_U0: begin
                     acc_in = sat_add64(acc_ff, res); op_in = gfc_pkg::OP_U1;
                  end
                  gfc_pkg::OP_U1: begin
                     // lane output, then shift the tap line
                     s64 = sat_tap(sat_add64(acc_ff, res));
                     if (!lane_ff) begin
                        ur_in    = TAP_WIDTH'(s64);
                        rt_in[3] = rt_ff[2];
                        rt_in[2] = rt_ff[1];
                        rt_in[1] = rt_ff[0];
                        rt_in[0] = p0_ff;
                        lane_in  = 1'b1;
                        op_in    = gfc_pkg::OP_DRV;
                     end else begin
                        ui_in    = TAP_WIDTH'(s64);
                        it_in[3] = it_ff[2];
                        it_in[2] = it_ff[1];
                        it_in[1] = it_ff[0];
                        it_in[0] = p0_ff;
                        op_in    = gfc_pkg::OP_RE0;
                     end
                  end
                  gfc_pkg::OP_RE0: begin re_in = res; op_in = gfc_pkg::OP_RE1; end
                  gfc_pkg::OP_RE1: begin
                     re_in = sat_add64(re_ff, res); op_in = gfc_pkg::OP_MEM;
                  end
                  gfc_pkg::OP_MEM: begin
                     mem_in = sat32(res);
                     if (hwr_ff && res[63]) mem_in = '0;
                     op_in = gfc_pkg::OP_ENVK;
                  end
                  gfc_pkg::OP_ENVK: begin
                     envk_in  = BW'(res);
                     state_in = gfc_pkg::ST_CORD_INIT;
                  end
                  gfc_pkg::OP_ENV: begin
                     if (res[63]) env_in = '0;
                     else if (res > 64'sd2147483647) env_in = {31{1'b1}};
                     else env_in = res[30:0];
                     state_in = gfc_pkg::ST_WRAP_INIT;
                  end
                  gfc_pkg::OP_FREQ: begin
                     if (havep_ff) begin
                        freq_in   = sat26(sat_add64(64'($signed({1'b0, cf_ff})), res));
                        fvalid_in = 1'b1;
                     end else begin
                        freq_in   = '0;
                        fvalid_in = 1'b0;
                     end
                     last_in  = ph_ff;
                     havep_in = 1'b1;
                     op_in    = gfc_pkg::OP_NC0;
                  end
                  gfc_pkg::OP_NC0: begin tmp_in = res; op_in = gfc_pkg::OP_NC1; end
                  gfc_pkg::OP_NC1: begin
                     nc_in = sat32(sat_add64(tmp_ff, res)); op_in = gfc_pkg::OP_NS0;
                  end
                  gfc_pkg::OP_NS0: begin tmp_in = res; op_in = gfc_pkg::OP_NS1; end
                  gfc_pkg::OP_NS1: begin
                     osc_sin_in = sat32(sat_sub64(tmp_ff, res));
                     osc_cos_in = nc_ff;
                     state_in   = gfc_pkg::ST_DONE;
                  end
                  default: state_in = gfc_pkg::ST_DONE;
               endcase
            end
         end

         // scale down and fold the left half plane by pi
         gfc_pkg::ST_CORD_INIT: begin
            cx0     = 64'(ur_ff) >>> 2;
            cy0     = 64'(ui_ff) >>> 2;
            step_in = '0;
            if (cx0 < 0) begin
               z_in  = (cy0 >= 0) ? gfc_pkg::PI_Q30 : -gfc_pkg::PI_Q30;
               cx_in = -cx0;
               cy_in = -cy0;
            end else begin
               z_in  = '0;
               cx_in = cx0;
               cy_in = cy0;
            end
            if (cx0 == 0 && cy0 == 0) begin
               z_in     = '0;
               op_in    = gfc_pkg::OP_ENV;
               state_in = gfc_pkg::ST_ISSUE;
            end else begin
               state_in = gfc_pkg::ST_CORDIC;
            end
         end

         // one vectoring rotation per cycle
         gfc_pkg::ST_CORDIC: begin
            if (cy_ff > 0) begin
               cx_in = cx_ff + (cy_ff >>> step_ff);
               cy_in = cy_ff - (cx_ff >>> step_ff);
               z_in  = z_ff + gfc_pkg::atan_q30(5'(step_ff));
            end else begin
               cx_in = cx_ff - (cy_ff >>> step_ff);
               cy_in = cy_ff + (cx_ff >>> step_ff);
               z_in  = z_ff - gfc_pkg::atan_q30(5'(step_ff));
            end
            step_in = step_ff + CW'(1);
            if (step_ff == CW'(CORDIC_STEPS - 1)) begin
               op_in    = gfc_pkg::OP_ENV;
               state_in = gfc_pkg::ST_ISSUE;
            end
         end

         // phase jump against the last phase
         gfc_pkg::ST_WRAP_INIT: begin
            ph0  = 35'((z_ff + 34'sd32) >>> 6);
            dnew = ph0 - 35'(last_ff);
            d_in = dnew;
            k_in = 3'(gfc_pkg::WRAP_STEPS - 1);
            if (dnew > gfc_pkg::PI_Q24 || dnew < -gfc_pkg::PI_Q24) begin
               tnew     = dnew + gfc_pkg::PI_Q24;
               neg_in   = tnew[34];
               m_in     = tnew[34] ? -tnew : tnew;
               wrap_in  = 1'b1;
               state_in = gfc_pkg::ST_WRAP;
            end else begin
               wrap_in  = 1'b0;
               state_in = gfc_pkg::ST_WRAP_FIX;
            end
         end

         // reduce the magnitude by 2*pi multiples, largest first
         gfc_pkg::ST_WRAP: begin
            lim = gfc_pkg::TWO_PI_Q24 <<< k_ff;
            if (m_ff >= lim) m_in = m_ff - lim;
            k_in = k_ff - 3'd1;
            if (k_ff == 3'd0) state_in = gfc_pkg::ST_WRAP_FIX;
         end

         // floor-mod correction, unwrapped phase and its step
         gfc_pkg::ST_WRAP_FIX: begin
            r = d_ff;
            if (wrap_ff) begin
               mm = (neg_ff && m_ff != 0) ? gfc_pkg::TWO_PI_Q24 - m_ff : m_ff;
               r  = mm - gfc_pkg::PI_Q24;
               if (r == -gfc_pkg::PI_Q24 && d_ff > 0) r = gfc_pkg::PI_Q24;
            end
            psum     = 35'(last_ff) + r;
            phs      = sat32(64'(psum));
            ph_in    = phs;
            diff_in  = 34'(phs) - 34'(last_ff);
            op_in    = gfc_pkg::OP_FREQ;
            state_in = gfc_pkg::ST_ISSUE;
         end

         gfc_pkg::ST_DONE: begin
            if (!ovalid_ff || out_ready) begin
               ovalid_in = 1'b1;
               omem_in   = mem_ff;
               oenv_in   = env_ff;
               oph_in    = ph_ff;
               ofreq_in  = freq_ff;
               ofv_in    = fvalid_ff;
               state_in  = gfc_pkg::ST_IDLE;
            end
         end

         default: state_in = gfc_pkg::ST_IDLE;
      endcase
   end

   // control and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= gfc_pkg::ST_IDLE;
         ovalid_ff  <= 1'b0;
         osc_cos_ff <= gfc_pkg::ONE_Q30;
         osc_sin_ff <= '0;
         last_ff    <= '0;
         havep_ff   <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            rt_ff[i] <= '0;
            it_ff[i] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         ovalid_ff  <= ovalid_in;
         osc_cos_ff <= osc_cos_in;
         osc_sin_ff <= osc_sin_in;
         last_ff    <= last_in;
         havep_ff   <= havep_in;
         rt_ff      <= rt_in;
         it_ff      <= it_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      op_ff     <= op_in;      lane_ff   <= lane_in;   x_ff    <= x_in;
      a2_ff     <= a2_in;      a3_ff     <= a3_in;     a4_ff   <= a4_in;
      acc_ff    <= acc_in;     p0_ff     <= p0_in;
      ur_ff     <= ur_in;      ui_ff     <= ui_in;
      re_ff     <= re_in;      mem_ff    <= mem_in;    envk_ff <= envk_in;
      cx_ff     <= cx_in;      cy_ff     <= cy_in;     z_ff    <= z_in;
      step_ff   <= step_in;    env_ff    <= env_in;
      d_ff      <= d_in;       m_ff      <= m_in;      neg_ff  <= neg_in;
      wrap_ff   <= wrap_in;    k_ff      <= k_in;
      ph_ff     <= ph_in;      diff_ff   <= diff_in;
      freq_ff   <= freq_in;    fvalid_ff <= fvalid_in;
      tmp_ff    <= tmp_in;     nc_ff     <= nc_in;
      omem_ff   <= omem_in;    oenv_ff   <= oenv_in;   oph_ff  <= oph_in;
      ofreq_ff  <= ofreq_in;   ofv_ff    <= ofv_in;
   end

   assign out_valid           = ovalid_ff;
   assign out_membrane        = omem_ff;
   assign out_envelope        = oenv_ff;
   assign out_phase           = oph_ff;
   assign out_prev_freq       = ofreq_ff;
   assign out_prev_freq_valid = ofv_ff;

endmodule

`default_nettype wire

@@ hw/rtl/gammatone_filter_channel.sv @@
// ----------------------------------------------------------------------------
// gammatone_filter_channel: one channel of a 4th-order gammatone filter
// Mixes each sample to baseband, runs the complex recursive filter, and
// returns membrane output, envelope, unwrapped phase and previous frequency.
//
//   channel   direction  handshake              payload
//   req_      in         req_tvalid/req_tready  tdata: sample; tuser: block_start
//   rsp_      out        rsp_tvalid/rsp_tready  tdata: 4 fields; tuser: valid flag
//   csr_      in         csr_we                 csr_addr, csr_wdata
//
// All 27 products go through the one shared serial multiplier, each one issued,
// accumulated over its 41 operand bits and rounded. A zero vector skips the
// CORDIC steps, and a phase jump within pi skips the folding steps.
// Reset is synchronous; it restores register defaults and clears the taps.
// A two-entry queue takes samples while one is computed, and a finished
// result waits in the output register while the next sample starts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gammatone_filter_channel #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int TAP_WIDTH    = 56,
   parameter int CORDIC_STEPS = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // sample
   input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] req_tdata,
   // block_start
   input  logic                                   req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // membrane, envelope, phase, prev_freq, zero fill
   output logic [127:0]                           rsp_tdata,
   // prev_freq_valid
   output logic                                   rsp_tuser,
   input  logic                                   csr_we,
   input  logic [gfc_pkg::CSR_ADDR_W-1:0]         csr_addr,
   input  logic [gfc_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   logic                           q_valid, q_ready, q_block_start;
   logic signed [SAMPLE_WIDTH-1:0] q_sample;
   gfc_pkg::mul_req_type           mul_req;
   gfc_pkg::mul_rsp_type           mul_rsp;
   logic [31:0]                    membrane, phase;
   logic [30:0]                    envelope;
   logic [25:0]                    prev_freq;

   gfc_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_sample      ($signed(req_tdata[SAMPLE_WIDTH-1:0])),
      .in_block_start (req_tuser),
      .q_valid        (q_valid),
      .q_ready        (q_ready),
      .q_sample       (q_sample),
      .q_block_start  (q_block_start)
   );

   gfc_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   gfc_back #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .TAP_WIDTH    (TAP_WIDTH),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_addr            (csr_addr),
      .csr_wdata           (csr_wdata),
      .q_valid             (q_valid),
      .q_ready             (q_ready),
      .q_sample            (q_sample),
      .q_block_start       (q_block_start),
      .mul_req             (mul_req),
      .mul_rsp             (mul_rsp),
      .out_valid           (rsp_tvalid),
      .out_ready           (rsp_tready),
      .out_membrane        (membrane),
      .out_envelope        (envelope),
      .out_phase           (phase),
      .out_prev_freq       (prev_freq),
      .out_prev_freq_valid (rsp_tuser)
   );

   assign rsp_tdata = {7'd0, prev_freq, phase, envelope, membrane};

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for gammatone_filter_channel
// The bench predicts each response word with a bit-true fixed-point model
// kept in a scoreboard class, and checks it field by field. Register
// settings change between phases, at both range extremes among them.
// Random stalls are applied on both the sample side and the response side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   typedef longint signed s64_type;

   typedef struct packed {
      logic [31:0] membrane;
      logic [30:0] envelope;
      logic [31:0] phase;
      logic [25:0] prev_freq;
      logic        freq_valid;
   } gt_word_type;

   // Bit-true channel predictor plus the queue of expected response words
   class gammatone_scoreboard;
      s64_type     decay, gain, cos_step, sin_step, hwr, cf, fs;
      s64_type     taps[2][4];
      s64_type     osc_c, osc_s, last_ph;
      bit          have_prev;
      gt_word_type expected_q[$];
      int          errors;

      function void clear();
         decay = 64'd4072000000; gain = 64'd2903000;
         cos_step = 64'd992000000; sin_step = 64'd410900000;
         hwr = 0; cf = 64'd256000; fs = 64'd651900;
         foreach (taps[i, k]) taps[i][k] = 0;
         osc_c = gfc_pkg::ONE_Q30; osc_s = 0; last_ph = 0; have_prev = 0;
         errors = 0;
      endfunction

      function void set_reg(gfc_pkg::csr_index_type idx, logic [39:0] v);
         case (idx)
            gfc_pkg::CSR_DECAY: decay = s64_type'(v[31:0]);
            gfc_pkg::CSR_GAIN:  gain = s64_type'(v);
            gfc_pkg::CSR_COS:   cos_step = s64_type'($signed(v[31:0]));
            gfc_pkg::CSR_SIN:   sin_step = s64_type'($signed(v[31:0]));
            gfc_pkg::CSR_HWR:   hwr = s64_type'(v[0]);
            gfc_pkg::CSR_CF:    cf = s64_type'(v[23:0]);
            gfc_pkg::CSR_FS:    fs = s64_type'(v[23:0]);
            default: ;
         endcase
      endfunction

      // round to nearest (ties up), shift right by n, saturate to 64 bits
      function s64_type rmul(s64_type x, s64_type y, int n);
         logic signed [127:0] px, py, p;
         px = x; py = y;
         p = px * py;
         p = p + (128'sd1 <<< (n - 1));
         p = p >>> n;
         if (p > 128'sd9223372036854775807) return 64'h7FFF_FFFF_FFFF_FFFF;
         if (p < -128'sd9223372036854775808) return 64'h8000_0000_0000_0000;
         return s64_type'(p);
      endfunction

      function s64_type sadd(s64_type a, s64_type b);
         logic signed [64:0] s;
         s = {a[63], a} + {b[63], b};
         if (s[64] != s[63]) return s[64] ? 64'h8000_0000_0000_0000
                                          : 64'h7FFF_FFFF_FFFF_FFFF;
         return s64_type'(s[63:0]);
      endfunction

      function s64_type clampw(s64_type v, int w);
         s64_type hi;
         hi = (s64_type'(1) <<< (w - 1)) - 1;
         if (v > hi) return hi;
         if (v < -hi - 1) return -hi - 1;
         return v;
      endfunction

      // one lane of the 4th-order recursion; shifts the taps
      function s64_type run_lane(int lane, s64_type drive, s64_type c[4], s64_type c1,
                                 s64_type c5);
         s64_type p0, u0;
         p0 = drive;
         for (int k = 0; k < 4; k++) p0 = sadd(p0, rmul(taps[lane][k], c[k], 32));
         p0 = clampw(p0, 56);
         u0 = sadd(p0, rmul(taps[lane][0], c1, 32));
         u0 = clampw(sadd(u0, rmul(taps[lane][1], c5, 32)), 56);
         taps[lane][3] = taps[lane][2]; taps[lane][2] = taps[lane][1];
         taps[lane][1] = taps[lane][0]; taps[lane][0] = p0;
         return u0;
      endfunction

      function void push_sample(logic [15:0] smp, logic bstart);
         s64_type x, a2, a3, a4, c[4], ur, ui, re, mem, cx, cy, z, nx;
         s64_type envk, env, ph, d, r, freq, nc, ns;
         gt_word_type w;
         x = s64_type'($signed(smp));
         if (bstart) begin
            osc_c = gfc_pkg::ONE_Q30; osc_s = 0; last_ph = 0; have_prev = 0;
         end
         a2 = rmul(decay, decay, 32); a3 = rmul(a2, decay, 32); a4 = rmul(a3, decay, 32);
         c[0] = 4 * decay; c[1] = -6 * a2; c[2] = 4 * a3; c[3] = -a4;
         ur = run_lane(0, rmul(osc_c, x, 13), c, 4 * decay, a2);
         ui = run_lane(1, rmul(osc_s, x, 13), c, 4 * decay, a2);

         re = sadd(rmul(ur, osc_c, 30), rmul(ui, osc_s, 30));
         mem = clampw(rmul(re, gain, 41), 32);
         if (hwr != 0 && mem < 0) mem = 0;

         // vectoring CORDIC with pre-rotation for the left half plane
         cx = ur >>> 2; cy = ui >>> 2; z = 0;
         if (cx < 0) begin
            z = (cy >= 0) ? s64_type'(gfc_pkg::PI_Q30) : -s64_type'(gfc_pkg::PI_Q30);
            cx = -cx; cy = -cy;
         end
         if (cx != 0 || cy != 0) begin
            for (int i = 0; i < 24; i++) begin
               if (cy > 0) begin
                  nx = cx + (cy >>> i); cy = cy - (cx >>> i);
                  z += s64_type'(gfc_pkg::atan_q30(i[4:0]));
               end else begin
                  nx = cx - (cy >>> i); cy = cy + (cx >>> i);
                  z -= s64_type'(gfc_pkg::atan_q30(i[4:0]));
               end
               cx = nx;
            end
         end else z = 0;
         envk = rmul(gain, s64_type'(gfc_pkg::KINV_Q32), 32);
         env = rmul(cx, envk, 39);
         if (env < 0) env = 0;
         if (env > 64'd2147483647) env = 64'd2147483647;

         // phase unwrap against the previous sample
         ph = (z + 32) >>> 6;
         d = ph - last_ph;
         if (d > s64_type'(gfc_pkg::PI_Q24) || d < -s64_type'(gfc_pkg::PI_Q24)) begin
            r = (d + s64_type'(gfc_pkg::PI_Q24)) % s64_type'(gfc_pkg::TWO_PI_Q24);
            if (r < 0) r += s64_type'(gfc_pkg::TWO_PI_Q24);
            r -= s64_type'(gfc_pkg::PI_Q24);
            if (r == -s64_type'(gfc_pkg::PI_Q24) && d > 0) r = s64_type'(gfc_pkg::PI_Q24);
            d = r;
         end
         ph = clampw(last_ph + d, 32);
         freq = 0;
         if (have_prev) freq = clampw(sadd(cf, rmul(ph - last_ph, fs, 24)), 26);
         w.freq_valid = have_prev;
         last_ph = ph;
         have_prev = 1;

         nc = clampw(sadd(rmul(cos_step, osc_c, 30), rmul(sin_step, osc_s, 30)), 32);
         ns = clampw(sadd(rmul(cos_step, osc_s, 30), -rmul(sin_step, osc_c, 30)), 32);
         osc_c = nc; osc_s = ns;

         w.membrane = mem[31:0]; w.envelope = env[30:0];
         w.phase = ph[31:0]; w.prev_freq = freq[25:0];
         expected_q.push_back(w);
      endfunction

      function void check_word(logic [127:0] data, logic user);
         gt_word_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: response word with none expected", $time);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (data[31:0] !== e.membrane) begin
            $display("%0t: membrane exp %h got %h", $time, e.membrane, data[31:0]);
            errors++;
         end
         if (data[62:32] !== e.envelope) begin
            $display("%0t: envelope exp %h got %h", $time, e.envelope, data[62:32]);
            errors++;
         end
         if (data[94:63] !== e.phase) begin
            $display("%0t: phase exp %h got %h", $time, e.phase, data[94:63]);
            errors++;
         end
         if (data[120:95] !== e.prev_freq) begin
            $display("%0t: prev_freq exp %h got %h", $time, e.prev_freq, data[120:95]);
            errors++;
         end
         if (data[127:121] !== 7'd0) begin
            $display("%0t: fill exp 0 got %h", $time, data[127:121]);
            errors++;
         end
         if (user !== e.freq_valid) begin
            $display("%0t: prev_freq_valid exp %b got %b", $time, e.freq_valid, user);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [15:0]  req_tdata = '0;   // sample
   logic         req_tuser = 0;    // block_start
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [127:0] rsp_tdata;        // membrane, envelope, phase, prev_freq, fill
   logic         rsp_tuser;        // prev_freq_valid
   logic         csr_we = 0;
   logic [gfc_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [gfc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   gammatone_scoreboard sb;
   bit   send_stalls = 1;
   bit   recv_stalls = 1;
   int   quiet_cycles = 0;

   localparam int WATCHDOG_LIMIT = 20000;

   gammatone_filter_channel dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // accepted words on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata, rsp_tuser);
         if (req_tvalid && req_tready) sb.push_sample(req_tdata, req_tuser);
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // response side back-pressure
   initial begin
      int gap;
      @(negedge clock);
      wait (!reset);
      forever begin
         @(negedge clock);
         gap = recv_stalls ? $urandom_range(0, 18) : 0;
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_sample(logic [15:0] smp, logic bstart);
      int gap;
      gap = send_stalls ? $urandom_range(0, 18) : 0;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= smp;
      req_tuser <= bstart;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // waits until all responses are in; block is idle afterwards
   task automatic drain();
      req_tvalid <= 0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_regs(logic [39:0] v[7]);
      for (int i = 0; i < 7; i++) begin
         csr_we <= 1;
         csr_addr <= gfc_pkg::CSR_ADDR_W'(i);
         csr_wdata <= v[i];
         sb.set_reg(gfc_pkg::csr_index_type'(i), v[i]);
         @(negedge clock);
      end
      csr_we <= 0;
      @(negedge clock);
   endtask

   function automatic logic [39:0] rand_q30();
      s64_type v;
      v = s64_type'($urandom_range(0, 32'h8000_0000)) - 64'd1073741824;
      return {8'd0, v[31:0]};
   endfunction

   initial begin
      logic [39:0] regs[7];
      logic [15:0] smp;
      sb = new();
      sb.clear();
      repeat (8) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: zero vector, full-scale extremes, block restarts
      send_sample(16'h0000, 1'b0);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h8000, 1'b1);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h0001, 1'b0);
      send_sample(16'h0000, 1'b1);
      for (int i = 0; i < 8; i++) send_sample(i[0] ? 16'h8000 : 16'h7FFF, i == 5);
      drain();

      for (int phase_n = 0; phase_n < 7; phase_n++) begin
         case (phase_n)
            0: regs = '{40'd0, 40'd0, 40'hC000_0000, 40'hC000_0000, 40'd1, 40'd0, 40'd0};
            1: regs = '{40'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 40'h4000_0000, 40'h4000_0000,
                        40'd0, 40'hFF_FFFF, 40'hFF_FFFF};
            default: begin
               regs[0] = 40'($urandom_range(32'hE000_0000, 32'hFFF0_0000));
               regs[1] = (phase_n % 2) ? {8'($urandom), 32'($urandom)}
                                       : 40'($urandom_range(0, 32'h0100_0000));
               regs[2] = rand_q30();
               regs[3] = rand_q30();
               regs[4] = 40'($urandom_range(0, 1));
               regs[5] = 40'($urandom_range(0, 24'hFF_FFFF));
               regs[6] = 40'($urandom_range(0, 24'hFF_FFFF));
            end
         endcase
         write_regs(regs);
         send_stalls = (phase_n != 3);
         recv_stalls = (phase_n != 4);
         for (int i = 0; i < 108; i++) begin
            smp = 16'($urandom);
            if ($urandom_range(0, 2) == 0) smp = 16'($signed(smp) >>> $urandom_range(0, 14));
            send_sample(smp, $urandom_range(0, 9) == 0);
         end
         drain();
      end

      if (sb.errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/gfc_pkg.sv
hw/rtl/gfc_front.sv
hw/rtl/gfc_mul.sv
hw/rtl/gfc_back.sv
hw/rtl/gammatone_filter_channel.sv
tb/sv/tb.sv
